[rtl/broadcast_mailbox_port_device_assert.svh]
// Assertion helpers for the mailbox device; clk and rst_n must be in scope.
`ifndef BROADCAST_MAILBOX_PORT_DEVICE_ASSERT_SVH
`define BROADCAST_MAILBOX_PORT_DEVICE_ASSERT_SVH

// Consequent holds in the same cycle as the antecedent.
`define BMPD_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("mailbox device assertion failed");

// Consequent holds in the cycle after the antecedent.
`define BMPD_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("mailbox device assertion failed");

`endif

[rtl/bmpd_pkg.sv]
package bmpd_pkg;

    typedef enum logic [1:0] {
        OP_WDATA = 2'd0,
        OP_RDATA = 2'd1,
        OP_WACK  = 2'd2,
        OP_RACK  = 2'd3
    } op_t;

    typedef enum logic [2:0] {
        PH_IDLE   = 3'd0,
        PH_WCOUNT = 3'd1,
        PH_WDATA  = 3'd2,
        PH_WACK   = 3'd3,
        PH_RCOUNT = 3'd4,
        PH_RDATA  = 3'd5,
        PH_RACK   = 3'd6
    } phase_t;

    typedef struct packed {
        logic accept;
        logic exec;
        logic fetch;
        logic copy_step;
        logic load_out;
    } dp_cmd_t;

    typedef struct packed {
        logic need_fetch;
        logic need_copy;
        logic copy_done;
    } dp_status_t;

    localparam logic REG_READER_COUNT = 1'b0;
    localparam logic [2:0] READER_COUNT_RESET = 3'd1;

endpackage

[rtl/bmpd_ram.sv]
module bmpd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                                 clk,
    input  logic                                 we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                     wdata,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                     rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

[rtl/bmpd_ctrl.sv]
module bmpd_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    output logic                 out_valid,
    input  logic                 out_ready,
    input  bmpd_pkg::dp_status_t status,
    output bmpd_pkg::dp_cmd_t    cmd
);

    import bmpd_pkg::*;

    typedef enum logic [4:0] {
        ST_IDLE  = 5'b00001,
        ST_EXEC  = 5'b00010,
        ST_FETCH = 5'b00100,
        ST_COPY  = 5'b01000,
        ST_HOLD  = 5'b10000
    } state_t;

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;

    always_comb
    begin
        state_next = state_reg;
        cmd = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.accept = 1'b1;
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                cmd.exec = 1'b1;
                priority if (status.need_fetch)
                    state_next = ST_FETCH;
                else if (status.need_copy)
                    state_next = ST_COPY;
                else
                    state_next = ST_HOLD;
            end
            ST_FETCH:
            begin
                cmd.fetch = 1'b1;
                state_next = ST_HOLD;
            end
            ST_COPY:
            begin
                cmd.copy_step = 1'b1;
                if (status.copy_done)
                    state_next = ST_HOLD;
            end
            ST_HOLD:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    cmd.load_out = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.load_out)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign in_ready  = (state_reg == ST_IDLE);
    assign out_valid = out_valid_reg;

endmodule

[rtl/bmpd_dp.sv]
module bmpd_dp #(
    parameter int SESSIONS   = 4,
    parameter int SLOT_BYTES = 256
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  bmpd_pkg::dp_cmd_t    cmd,
    output bmpd_pkg::dp_status_t status,
    input  logic [1:0]           in_operation,
    input  logic [1:0]           in_session,
    input  logic [7:0]           in_byte,
    input  logic [2:0]           reader_count,
    output logic [7:0]           read_byte,
    output logic                 wait_res,
    output logic                 round_was_empty
);

    import bmpd_pkg::*;

    localparam int SIDX_W = (SESSIONS > 1) ? $clog2(SESSIONS) : 1;
    localparam int SA     = $clog2(SLOT_BYTES);
    localparam int LEN_W  = $clog2(SLOT_BYTES + 1);
    localparam int STG_AW = SIDX_W + SA;
    localparam int STG_DEPTH = 2 ** STG_AW;

    op_t        op_reg;
    logic [1:0] sess_reg;
    logic [7:0] byte_reg;

    phase_t            phase_reg [SESSIONS];
    logic [31:0]       bidx_reg  [SESSIONS];
    logic [31:0]       cw_reg    [SESSIONS];
    logic [LEN_W-1:0]  len_reg   [SESSIONS];
    logic [LEN_W-1:0]  pos_reg   [SESSIONS];
    logic              end_reg   [SESSIONS];

    logic [LEN_W-1:0] shared_len_reg, n_sl;
    logic             shared_full_reg, n_sf;
    logic [2:0]       rf_reg, n_rf;

    logic [7:0] res_byte_reg;
    logic       res_wait_reg, res_end_reg;
    logic [7:0] out_byte_reg;
    logic       out_wait_reg, out_end_reg;

    logic [LEN_W-1:0]  cnt_reg, clen_reg;
    logic              cdir_reg;
    logic [SIDX_W-1:0] csess_reg;
    logic              pend_reg;
    logic [SA-1:0]     waddr_reg;

    logic              sess_ok, blocks;
    logic [SIDX_W-1:0] s;
    phase_t            ph, n_ph;
    logic [31:0]       bi, cw, n_bi, n_cw, cwn, nxt;
    logic [LEN_W-1:0]  ln, ps, n_ln, n_ps;
    logic              ef, n_ef;
    logic [1:0]        idx;
    logic              last;
    logic [7:0]        rd;
    logic              wt, stg_wr, fetch, commit, join_slot;

    logic              stg_we, sh_we;
    logic [STG_AW-1:0] stg_waddr, stg_raddr;
    logic [7:0]        stg_wdata, stg_rdata, sh_rdata;
    logic [SA-1:0]     sh_raddr;

    assign sess_ok = (int'(sess_reg) < SESSIONS);
    assign s       = SIDX_W'(sess_reg);
    assign blocks  = shared_full_reg && (reader_count != 3'd0);

    always_comb
    begin
        ph = sess_ok ? phase_reg[s] : PH_IDLE;
        bi = sess_ok ? bidx_reg[s]  : '0;
        cw = sess_ok ? cw_reg[s]    : '0;
        ln = sess_ok ? len_reg[s]   : '0;
        ps = sess_ok ? pos_reg[s]   : '0;
        ef = sess_ok ? end_reg[s]   : 1'b0;
    end

    always_comb
    begin
        n_ph = ph;
        n_bi = bi;
        n_cw = cw;
        n_ln = ln;
        n_ps = ps;
        n_ef = ef;
        n_sl = shared_len_reg;
        n_sf = shared_full_reg;
        n_rf = rf_reg;
        rd = '0;
        wt = 1'b0;
        stg_wr = 1'b0;
        fetch = 1'b0;
        commit = 1'b0;
        join_slot = 1'b0;
        idx = bi[1:0];
        cwn = '0;
        nxt = '0;
        last = 1'b0;
        if (sess_ok)
        begin
            unique case (op_reg)
                OP_WDATA:
                begin
                    if (ph == PH_IDLE)
                    begin
                        n_ph = PH_WCOUNT;
                        n_bi = '0;
                        n_cw = '0;
                    end
                    idx = n_bi[1:0];
                    if (n_ph == PH_WCOUNT)
                    begin
                        cwn = n_cw | (32'(byte_reg) << {idx, 3'b000});
                        if (idx == 2'd3 && cwn == 32'd0 && blocks)
                        begin
                            wt = 1'b1;
                        end
                        else
                        begin
                            n_cw = cwn;
                            n_bi = 32'(idx) + 32'd1;
                            if (idx == 2'd3)
                            begin
                                n_bi = '0;
                                n_ln = '0;
                                if (cwn == 32'd0)
                                    commit = 1'b1;
                                else
                                    n_ph = PH_WDATA;
                            end
                        end
                    end
                    else if (n_ph == PH_WDATA)
                    begin
                        nxt = n_bi + 32'd1;
                        last = (nxt == n_cw);
                        if (last && blocks)
                        begin
                            wt = 1'b1;
                        end
                        else
                        begin
                            if (int'(n_ln) < SLOT_BYTES)
                            begin
                                stg_wr = 1'b1;
                                n_ln = n_ln + 1'b1;
                            end
                            n_bi = nxt;
                            if (last)
                                commit = 1'b1;
                        end
                    end
                end
                OP_RDATA:
                begin
                    if (ph == PH_IDLE)
                    begin
                        if (!shared_full_reg)
                        begin
                            wt = 1'b1;
                        end
                        else
                        begin
                            n_ln = shared_len_reg;
                            n_cw = 32'(shared_len_reg);
                            n_bi = '0;
                            n_ps = '0;
                            n_ph = PH_RCOUNT;
                            join_slot = 1'b1;
                        end
                    end
                    if (!wt)
                    begin
                        idx = n_bi[1:0];
                        if (n_ph == PH_RCOUNT)
                        begin
                            rd = 8'(n_cw >> {idx, 3'b000});
                            n_bi = 32'(idx) + 32'd1;
                            if (idx == 2'd3)
                            begin
                                n_ps = '0;
                                n_bi = '0;
                                if (n_ln != '0)
                                begin
                                    n_ph = PH_RDATA;
                                end
                                else
                                begin
                                    n_cw = '0;
                                    n_ph = PH_RACK;
                                    n_ef = 1'b1;
                                end
                            end
                        end
                        else if (n_ph == PH_RDATA)
                        begin
                            fetch = 1'b1;
                            n_ps = ps + 1'b1;
                            if (n_ps >= n_ln)
                            begin
                                n_cw = '0;
                                n_bi = '0;
                                n_ph = PH_RACK;
                            end
                        end
                    end
                end
                OP_WACK:
                begin
                    if (ph == PH_RACK)
                    begin
                        n_cw = cw | (32'(byte_reg) << {idx, 3'b000});
                        n_bi = 32'(idx) + 32'd1;
                        if (idx == 2'd3)
                        begin
                            n_rf = rf_reg + 3'd1;
                            if (n_rf == reader_count)
                                n_sf = 1'b0;
                            n_ph = PH_IDLE;
                            n_bi = '0;
                            n_cw = '0;
                        end
                    end
                end
                OP_RACK:
                begin
                    if (ph == PH_WACK)
                    begin
                        rd = 8'(cw >> {idx, 3'b000});
                        n_bi = 32'(idx) + 32'd1;
                        if (idx == 2'd3)
                        begin
                            n_ph = PH_IDLE;
                            n_bi = '0;
                        end
                    end
                end
                default:
                begin
                    wt = 1'b0;
                end
            endcase
            if (commit)
            begin
                n_sl = n_ln;
                n_sf = 1'b1;
                n_rf = '0;
                n_cw = 32'(n_ln);
                n_bi = '0;
                n_ph = PH_WACK;
                if (n_ln == '0)
                    n_ef = 1'b1;
            end
        end
    end

    assign status.need_fetch = fetch;
    assign status.need_copy  = commit || join_slot;
    assign status.copy_done  = (cnt_reg == clen_reg) && !pend_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            op_reg   <= op_t'(in_operation);
            sess_reg <= in_session;
            byte_reg <= in_byte;
        end
        if (cmd.exec)
        begin
            res_byte_reg <= rd;
            res_wait_reg <= wt;
            res_end_reg  <= sess_ok ? n_ef : 1'b0;
        end
        if (cmd.fetch)
        begin
            res_byte_reg <= stg_rdata;
        end
        if (cmd.load_out)
        begin
            out_byte_reg <= res_byte_reg;
            out_wait_reg <= res_wait_reg;
            out_end_reg  <= res_end_reg;
        end
        if (cmd.copy_step && cnt_reg < clen_reg)
        begin
            waddr_reg <= cnt_reg[SA-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < SESSIONS; i++)
            begin
                phase_reg[i] <= PH_IDLE;
                bidx_reg[i]  <= '0;
                cw_reg[i]    <= '0;
                len_reg[i]   <= '0;
                pos_reg[i]   <= '0;
                end_reg[i]   <= 1'b0;
            end
            shared_len_reg  <= '0;
            shared_full_reg <= 1'b0;
            rf_reg          <= '0;
            cnt_reg         <= '0;
            clen_reg        <= '0;
            cdir_reg        <= 1'b0;
            csess_reg       <= '0;
            pend_reg        <= 1'b0;
        end
        else
        begin
            if (cmd.exec && sess_ok)
            begin
                phase_reg[s] <= n_ph;
                bidx_reg[s]  <= n_bi;
                cw_reg[s]    <= n_cw;
                len_reg[s]   <= n_ln;
                pos_reg[s]   <= n_ps;
                end_reg[s]   <= n_ef;
                shared_len_reg  <= n_sl;
                shared_full_reg <= n_sf;
                rf_reg          <= n_rf;
                if (commit || join_slot)
                begin
                    cnt_reg   <= '0;
                    clen_reg  <= commit ? n_ln : shared_len_reg;
                    cdir_reg  <= join_slot;
                    csess_reg <= s;
                    pend_reg  <= 1'b0;
                end
            end
            if (cmd.copy_step)
            begin
                if (cnt_reg < clen_reg)
                begin
                    cnt_reg  <= cnt_reg + 1'b1;
                    pend_reg <= 1'b1;
                end
                else
                begin
                    pend_reg <= 1'b0;
                end
            end
        end
    end

    always_comb
    begin
        if (cmd.exec)
        begin
            stg_we    = stg_wr;
            stg_waddr = {s, ln[SA-1:0]};
            stg_wdata = byte_reg;
        end
        else
        begin
            stg_we    = pend_reg && cdir_reg;
            stg_waddr = {csess_reg, waddr_reg};
            stg_wdata = sh_rdata;
        end
        stg_raddr = cmd.copy_step ? {csess_reg, cnt_reg[SA-1:0]} : {s, ps[SA-1:0]};
    end

    assign sh_we    = pend_reg && !cdir_reg;
    assign sh_raddr = cnt_reg[SA-1:0];

    bmpd_ram #(
        .WIDTH (8),
        .DEPTH (STG_DEPTH)
    ) u_staging (
        .clk   (clk),
        .we    (stg_we),
        .waddr (stg_waddr),
        .wdata (stg_wdata),
        .raddr (stg_raddr),
        .rdata (stg_rdata)
    );

    bmpd_ram #(
        .WIDTH (8),
        .DEPTH (SLOT_BYTES)
    ) u_shared (
        .clk   (clk),
        .we    (sh_we),
        .waddr (waddr_reg),
        .wdata (stg_rdata),
        .raddr (sh_raddr),
        .rdata (sh_rdata)
    );

    assign read_byte       = out_byte_reg;
    assign wait_res        = out_wait_reg;
    assign round_was_empty = out_end_reg;

endmodule

[rtl/broadcast_mailbox_port_device.sv]
// A taken word passes through the EXEC and HOLD states, and a data byte read also through
// FETCH, before its result is loaded into the output register; no new word is taken until that load.
// A commit or a first read of a round also passes through the COPY state: the slot
// copy moves one byte per cycle through the single read port of the staging and shared RAMs.
// Reset (rst_n low, asynchronous): all sessions idle, slot empty, reader_count 1;
// RAM contents are not cleared and no clearing pass runs.
module broadcast_mailbox_port_device #(
    parameter int SESSIONS   = 4,
    parameter int SLOT_BYTES = 256
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] write_byte
    input  logic [3:0]  s_axis_tuser,   // [1:0] operation, [3:2] session
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [7:0]  m_axis_tdata,   // [7:0] read_byte
    output logic [1:0]  m_axis_tuser,   // [0] wait_res, [1] round_was_empty
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    import bmpd_pkg::*;

    dp_cmd_t    cmd;
    dp_status_t stat;
    logic [2:0] reader_count_reg;

    assign pready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            reader_count_reg <= READER_COUNT_RESET;
        else if (psel && penable && pwrite && pready && paddr[2] == REG_READER_COUNT)
            reader_count_reg <= pwdata[2:0];
    end

    assign prdata = (paddr[2] == REG_READER_COUNT) ? {29'd0, reader_count_reg} : 32'd0;

    bmpd_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .status    (stat),
        .cmd       (cmd)
    );

    bmpd_dp #(
        .SESSIONS   (SESSIONS),
        .SLOT_BYTES (SLOT_BYTES)
    ) u_dp (
        .clk             (clk),
        .rst_n           (rst_n),
        .cmd             (cmd),
        .status          (stat),
        .in_operation    (s_axis_tuser[1:0]),
        .in_session      (s_axis_tuser[3:2]),
        .in_byte         (s_axis_tdata),
        .reader_count    (reader_count_reg),
        .read_byte       (m_axis_tdata),
        .wait_res        (m_axis_tuser[0]),
        .round_was_empty (m_axis_tuser[1])
    );

`include "broadcast_mailbox_port_device_assert.svh"

    `BMPD_ASSERT_NEXT(a_busy_after_take, s_axis_tvalid && s_axis_tready, !s_axis_tready)
    `BMPD_ASSERT_SAME(a_copy_blocks_input, !stat.copy_done, !s_axis_tready)
    `BMPD_ASSERT_SAME(a_wait_reads_zero, m_axis_tvalid && m_axis_tuser[0], m_axis_tdata == 8'd0)

endmodule
